@@ design/icg_pkg.sv @@
// Package for the inversive congruential generator: item kind, status codes,
// register indexes, sequencer states, arithmetic op and request types.
`timescale 1ns / 1ps
`default_nettype none
package icg_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_HALT     = 2'd1,
    ST_PERIOD   = 2'd2,
    ST_REJECT   = 2'd3
  } status_e;

  localparam logic KIND_SEED = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic [1:0] REG_MODULUS    = 2'd0;
  localparam logic [1:0] REG_MULTIPLIER = 2'd1;
  localparam logic [1:0] REG_INCREMENT  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_CUR,
    S_RED_A,
    S_RED_C,
    S_DIV,
    S_QMUL,
    S_TSUB,
    S_AMUL,
    S_ADD,
    S_OUT
  } seq_e;

  typedef enum logic [1:0] {
    OP_MOD,
    OP_MULMOD
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } au_req_t;

endpackage
`default_nettype wire

@@ design/inversive_congruential_generator.sv @@
// Inversive congruential generator top: registers, state, step sequencer; uses icg_pkg, icg_arith.
// Latency: a seed, or a step while halted, answers on the cycle after its beat is accepted.
// A step runs shared-unit operations in turn: three reductions, three per Euclid round
// (divide, reduce quotient, multiply) and, when an inverse exists, one final multiply.
// Throughput: one item at a time; no new beat is taken until the result beat is taken.
// Reset: modulus 2147483647, multiplier 1, increment 0, all state zero.
`timescale 1ns / 1ps
`default_nettype none
module inversive_congruential_generator #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // seed_value
  input  wire logic        s_axis_tuser,  // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,  // value, step_count, status, zero fill
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import icg_pkg::*;

  localparam int W = VALUE_WIDTH;

  seq_e         st_q, st_d;
  logic [W-1:0] mod_q, mul_q, inc_q;
  logic [W-1:0] cur_q, start_q, r0_q, r1_q, t0_q, t1_q, a_q, c_q, inv_q;
  logic [31:0]  steps_q;
  logic         halted_q;
  status_e      status_q;
  logic         ovalid_q;

  au_req_t      req;
  logic [W-1:0] au_a, au_b, au_m, au_q, au_r, tnext, sumac, newv;
  logic [W:0]   s2;
  logic         au_done;
  logic [W-1:0] seed_w, cfg_w;
  logic         mod_bad, in_acc;

  icg_arith #(.W(W)) u_arith (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .a_i(au_a), .b_i(au_b),
    .m_i(au_m), .done_o(au_done), .quot_o(au_q), .res_o(au_r)
  );

  assign seed_w  = W'(s_axis_tdata);
  assign cfg_w   = W'(cfg_data_i);
  assign mod_bad = (mod_q < W'(2));
  assign s_axis_tready = (st_q == S_IDLE) && !ovalid_q;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign tnext   = (t0_q >= au_r) ? (t0_q - au_r) : (t0_q + (mod_q - au_r));
  assign s2      = {1'b0, inv_q} + {1'b0, c_q};
  assign sumac   = (s2 >= {1'b0, mod_q}) ? W'(s2 - {1'b0, mod_q}) : s2[W-1:0];
  assign newv    = sumac;

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE:    if (in_acc && s_axis_tuser == KIND_STEP && !halted_q && !mod_bad)
                   st_d = S_RED_CUR;
      S_RED_CUR: if (au_done) st_d = S_RED_A;
      S_RED_A:   if (au_done) st_d = S_RED_C;
      S_RED_C:   if (au_done) st_d = (r1_q == '0) ? S_OUT : S_DIV;
      S_DIV:     if (au_done) st_d = S_QMUL;
      S_QMUL:    if (au_done) st_d = S_TSUB;
      S_TSUB:    if (au_done)
                   st_d = (r1_q == '0) ? ((r0_q == W'(1)) ? S_AMUL : S_OUT) : S_DIV;
      S_AMUL:    if (au_done) st_d = S_ADD;
      S_ADD:     st_d = S_OUT;
      S_OUT:     st_d = S_IDLE;
      default:   st_d = S_IDLE;
    endcase
  end

  always_comb begin
    req  = '{start: 1'b0, op: OP_MOD};
    au_a = cur_q;
    au_b = '0;
    au_m = mod_q;
    case (st_q)
      S_IDLE: if (st_d == S_RED_CUR) req.start = 1'b1;
      S_RED_CUR: if (au_done) begin
        req.start = 1'b1; au_a = mul_q;
      end
      S_RED_A: if (au_done) begin
        req.start = 1'b1; au_a = inc_q;
      end
      S_RED_C: if (au_done && r1_q != '0) begin
        req.start = 1'b1; au_a = r0_q; au_m = r1_q;
      end
      S_DIV: if (au_done) begin
        req.start = 1'b1; req.op = OP_MOD; au_a = au_q;
      end
      S_QMUL: if (au_done) begin
        req.start = 1'b1; req.op = OP_MULMOD; au_a = au_r; au_b = t1_q;
      end
      S_TSUB: if (st_d == S_DIV) begin
        req.start = 1'b1; au_a = r0_q; au_m = r1_q;
      end else if (st_d == S_AMUL) begin
        req.start = 1'b1; req.op = OP_MULMOD; au_a = a_q; au_b = t1_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      mod_q    <= W'(32'd2147483647);
      mul_q    <= W'(1);
      inc_q    <= '0;
      cur_q    <= '0;
      start_q  <= '0;
      steps_q  <= '0;
      halted_q <= 1'b0;
      ovalid_q <= 1'b0;
      status_q <= ST_OK;
      r0_q     <= '0;
      r1_q     <= '0;
      t0_q     <= '0;
      t1_q     <= '0;
      a_q      <= '0;
      c_q      <= '0;
      inv_q    <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_MODULUS:    mod_q <= cfg_w;
          REG_MULTIPLIER: mul_q <= cfg_w;
          REG_INCREMENT:  inc_q <= cfg_w;
          default: ;
        endcase
      end
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      if (in_acc && st_d == S_IDLE) begin
        ovalid_q <= 1'b1;
        if (s_axis_tuser == KIND_SEED) begin
          if (mod_bad || seed_w >= mod_q) status_q <= ST_REJECT;
          else begin
            cur_q <= seed_w; start_q <= seed_w; steps_q <= '0;
            halted_q <= 1'b0; status_q <= ST_OK;
          end
        end else status_q <= ST_HALT;
      end
      case (st_q)
        S_RED_CUR: if (au_done) begin r0_q <= mod_q; r1_q <= au_r; t0_q <= '0;
                                       t1_q <= W'(1); end
        S_RED_A:   if (au_done) a_q <= au_r;
        S_RED_C:   if (au_done) begin
          c_q <= au_r;
          if (r1_q == '0) begin halted_q <= 1'b1; status_q <= ST_HALT; end
        end
        S_DIV:     if (au_done) begin r0_q <= r1_q; r1_q <= au_r; end
        S_TSUB:    if (au_done) begin
          t0_q <= t1_q; t1_q <= tnext;
          if (r1_q == '0 && r0_q != W'(1)) begin
            halted_q <= 1'b1; status_q <= ST_HALT;
          end
        end
        S_AMUL:    if (au_done) inv_q <= au_r;
        S_ADD: begin
          cur_q <= newv;
          if (steps_q != '1) steps_q <= steps_q + 32'd1;
          status_q <= (newv == start_q) ? ST_PERIOD : ST_OK;
        end
        S_OUT:     ovalid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = {6'd0, status_q, steps_q, 32'(cur_q)};

endmodule
`default_nettype wire

@@ design/icg_arith.sv @@
// Shared bit-serial arithmetic unit: quotient and remainder (restoring
// division) and modular multiply (double and add). Depends on icg_pkg.
`timescale 1ns / 1ps
`default_nettype none
module icg_arith #(
  parameter int W = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire icg_pkg::au_req_t req_i,
  input  wire logic [W-1:0]     a_i,
  input  wire logic [W-1:0]     b_i,
  input  wire logic [W-1:0]     m_i,
  output logic                  done_o,
  output logic [W-1:0]          quot_o,
  output logic [W-1:0]          res_o
);
  import icg_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic          busy_q, busy_d;
  op_e           op_q, op_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  r_q, r_d, x_q, x_d, u_q, u_d, mm_q, mm_d;
  logic [W:0]    sh, dbl, sum1;
  logic [W-1:0]  rd, ra;
  logic          done_q, done_d;

  always_comb begin
    sh   = {r_q, x_q[W-1]};
    dbl  = {1'b0, r_q} + {1'b0, r_q};
    rd   = (dbl >= {1'b0, mm_q}) ? W'(dbl - {1'b0, mm_q}) : dbl[W-1:0];
    sum1 = {1'b0, rd} + {1'b0, u_q};
    ra   = (sum1 >= {1'b0, mm_q}) ? W'(sum1 - {1'b0, mm_q}) : sum1[W-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    op_d   = op_q;
    cnt_d  = cnt_q;
    r_d    = r_q;
    x_d    = x_q;
    u_d    = u_q;
    mm_d   = mm_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = CW'(W);
      r_d    = '0;
      x_d    = a_i;
      u_d    = b_i;
      mm_d   = m_i;
    end else if (busy_q) begin
      if (op_q == OP_MOD) begin
        if (sh >= {1'b0, mm_q}) begin
          r_d = W'(sh - {1'b0, mm_q});
          x_d = {x_q[W-2:0], 1'b1};
        end else begin
          r_d = sh[W-1:0];
          x_d = {x_q[W-2:0], 1'b0};
        end
      end else begin
        r_d = x_q[W-1] ? ra : rd;
        x_d = {x_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MOD;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q  <= r_d;
    x_q  <= x_d;
    u_q  <= u_d;
    mm_q <= mm_d;
  end

  assign done_o = done_q;
  assign quot_o = x_q;
  assign res_o  = r_q;

endmodule
`default_nettype wire

@@ tb/sv/icg_scoreboard.sv @@
// Scoreboard for the inversive congruential generator: watches the config,
// input and output channels, predicts each result beat and compares it.
// Depends on icg_pkg.
`timescale 1ns / 1ps
module icg_scoreboard (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [71:0] m_axis_tdata,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  output int               errors_o,
  output int               pending_o
);
  import icg_pkg::*;

  typedef struct {
    logic [31:0] value;
    logic [31:0] steps;
    status_e     status;
  } icg_result_t;

  icg_result_t expected_results[$];
  longint unsigned mod_r, mul_r, inc_r;
  longint unsigned cur_val, seed_val, step_cnt;
  bit              halted;

  function automatic bit find_inverse(input longint unsigned v, input longint unsigned m,
                                      output longint unsigned inv);
    longint unsigned r0, r1, r2, t0, t1, t2, q, p;
    r0 = m; r1 = v % m; t0 = 0; t1 = 1; inv = 0;
    while (r1 != 0) begin
      q  = r0 / r1;
      r2 = r0 - q * r1;
      p  = ((q % m) * t1) % m;
      t2 = (t0 >= p) ? t0 - p : t0 + (m - p);
      r0 = r1; r1 = r2;
      t0 = t1; t1 = t2;
    end
    inv = t0;
    return r0 == 1;
  endfunction

  task automatic predict_beat(input logic kind, input logic [31:0] seed);
    icg_result_t     res;
    longint unsigned inv;
    res.status = ST_OK;
    if (kind == KIND_SEED) begin
      if (mod_r < 2 || seed >= mod_r) begin
        res.status = ST_REJECT;
      end else begin
        cur_val = seed; seed_val = seed; step_cnt = 0; halted = 0;
      end
    end else if (halted || mod_r < 2) begin
      res.status = ST_HALT;
    end else if (!find_inverse(cur_val, mod_r, inv)) begin
      halted = 1;
      res.status = ST_HALT;
    end else begin
      cur_val = (((mul_r % mod_r) * inv) % mod_r + inc_r % mod_r) % mod_r;
      if (step_cnt < 64'hFFFF_FFFF) step_cnt++;
      if (cur_val == seed_val) res.status = ST_PERIOD;
    end
    res.value = cur_val[31:0];
    res.steps = step_cnt[31:0];
    expected_results.push_back(res);
  endtask

  initial begin
    errors_o = 0;
    pending_o = 0;
    mod_r = 2147483647; mul_r = 1; inc_r = 0;
    cur_val = 0; seed_val = 0; step_cnt = 0; halted = 0;
  end

  always @(posedge clk_i) begin
    icg_result_t exp_r;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_MODULUS:    mod_r = cfg_data_i;
          REG_MULTIPLIER: mul_r = cfg_data_i;
          REG_INCREMENT:  inc_r = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_beat(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat %h", m_axis_tdata);
          errors_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (m_axis_tdata[31:0] !== exp_r.value) begin
            $error("value: expected %h, got %h", exp_r.value, m_axis_tdata[31:0]);
            errors_o++;
          end
          if (m_axis_tdata[63:32] !== exp_r.steps) begin
            $error("step_count: expected %h, got %h", exp_r.steps, m_axis_tdata[63:32]);
            errors_o++;
          end
          if (m_axis_tdata[65:64] !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, m_axis_tdata[65:64]);
            errors_o++;
          end
        end
      end
      pending_o = expected_results.size();
    end
  end
endmodule

@@ tb/sv/inversive_congruential_generator_test.sv @@
// Testbench top for the inversive congruential generator: clock, reset,
// config writes, seed and step beats, verdict. Depends on icg_pkg,
// icg_scoreboard and the generator RTL.
`timescale 1ns / 1ps
module inversive_congruential_generator_test;
  import icg_pkg::*;

  localparam longint CYCLE_LIMIT = 40_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          errors, pending;
  longint      cycles = 0;
  bit          idle_on = 1'b1;
  int          beats_sent = 0, seeds_sent = 0, phases = 0;
  logic [31:0] cur_mod = 32'd2147483647;

  always #5 clk_i = ~clk_i;

  inversive_congruential_generator dut (.*);

  icg_scoreboard scoreboard (
    .errors_o(errors), .pending_o(pending), .*
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("inversive_congruential_generator: mismatch");
      $finish;
    end
  end

  always @(negedge clk_i) m_axis_tready = !idle_on || ($urandom_range(99) >= 31);

  task automatic send_beat(input logic kind, input logic [31:0] seed);
    while (idle_on && $urandom_range(99) < 31) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = kind;
    s_axis_tdata  = kind == KIND_SEED ? seed : $urandom;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    beats_sent++;
    if (kind == KIND_SEED) seeds_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    if (idx == REG_MODULUS) cur_mod = data;
  endtask

  task automatic drain;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [31:0] m, input logic [31:0] a, input logic [31:0] c);
    drain();
    write_reg(REG_MODULUS, m);
    write_reg(REG_MULTIPLIER, a);
    write_reg(REG_INCREMENT, c);
    phases++;
  endtask

  function automatic logic [31:0] pick_reg;
    case ($urandom_range(4))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_modulus;
    case ($urandom_range(11))
      0: return 32'd2;
      1: return 32'd3;
      2: return 32'd7;
      3: return 32'd13;
      4: return 32'd251;
      5: return 32'd1000;
      6: return 32'd65521;
      7: return 32'hFFFF_FFFF;
      8: return 32'd4294967291;
      9: return $urandom;
      default: return $urandom_range(2, 5000);
    endcase
  endfunction

  initial begin
    logic [31:0] m;
    int          r;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset register values: halt before any seed, rejects, zero seed
    send_beat(KIND_STEP, 0);
    send_beat(KIND_STEP, 0);
    send_beat(KIND_SEED, 32'hFFFF_FFFF);
    send_beat(KIND_SEED, 32'd2147483647);
    send_beat(KIND_SEED, 32'd2147483646);
    send_beat(KIND_STEP, 0);
    send_beat(KIND_STEP, 0);
    send_beat(KIND_SEED, 32'd0);
    send_beat(KIND_STEP, 0);
    send_beat(KIND_STEP, 0);
    // short period, composite modulus, value above a shrunk modulus
    set_regs(32'd7, 32'd3, 32'd2);
    send_beat(KIND_SEED, 32'd3);
    repeat (8) send_beat(KIND_STEP, 0);
    set_regs(32'd12, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(KIND_SEED, 32'd4);
    send_beat(KIND_STEP, 0);
    set_regs(32'd2147483647, 32'd5, 32'd0);
    send_beat(KIND_SEED, 32'd1000);
    set_regs(32'd13, 32'd5, 32'd1);
    send_beat(KIND_STEP, 0);
    send_beat(KIND_STEP, 0);
    // invalid modulus
    set_regs(32'd1, 32'd1, 32'd0);
    send_beat(KIND_SEED, 32'd0);
    send_beat(KIND_STEP, 0);

    for (int p = 0; p < 12; p++) begin
      idle_on = (p != 1);
      m = (p == 0) ? 32'd7 : pick_modulus();
      set_regs(m, pick_reg(), pick_reg());
      send_beat(KIND_SEED, $urandom_range(0, m - 1));
      for (int i = 0; i < 85; i++) begin
        r = $urandom_range(99);
        if (r < 3) send_beat(KIND_SEED, $urandom);
        else if (r < 11) send_beat(KIND_SEED, $urandom_range(0, cur_mod - 1));
        else send_beat(KIND_STEP, 0);
      end
    end

    drain();
    $display("Ran %0d beats (%0d seeds) over %0d register settings in %0d cycles.",
             beats_sent, seeds_sent, phases, cycles);
    if (errors == 0) begin
      $display("inversive_congruential_generator: match");
    end else begin
      $display("inversive_congruential_generator: mismatch");
    end
    $finish;
  end
endmodule

@@ sim.f @@
design/icg_pkg.sv
design/icg_arith.sv
design/inversive_congruential_generator.sv
tb/sv/icg_scoreboard.sv
tb/sv/inversive_congruential_generator_test.sv
